[hw/rtl/rrp_pkg.sv]
// Shared types and constants for the request parser.
// Holds phase codes, event and error codes, framing characters and the
// limit and result structs; depends on nothing.
`default_nettype none

package rrp_pkg;

    // Field widths
    localparam int COUNT_W  = 21;
    localparam int LEN_W    = 30;
    localparam int INDEX_W  = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARRAY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LENGTH = 2'd1;
    localparam logic [COUNT_W-1:0]   MAX_ARRAY_COUNT_RST = 21'h100000;
    localparam logic [LEN_W-1:0]     MAX_BULK_LENGTH_RST = 30'h20000000;

    // Framing characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Parser phases
    localparam logic [3:0] PH_STAR     = 4'd0;
    localparam logic [3:0] PH_COUNT    = 4'd1;
    localparam logic [3:0] PH_COUNT_LF = 4'd2;
    localparam logic [3:0] PH_DOLLAR   = 4'd3;
    localparam logic [3:0] PH_LEN      = 4'd4;
    localparam logic [3:0] PH_LEN_LF   = 4'd5;
    localparam logic [3:0] PH_DATA     = 4'd6;
    localparam logic [3:0] PH_DATA_CR  = 4'd7;
    localparam logic [3:0] PH_DATA_LF  = 4'd8;

    // Event codes
    localparam logic [1:0] EV_ARG_HEADER = 2'd0;
    localparam logic [1:0] EV_ARG_DATA   = 2'd1;
    localparam logic [1:0] EV_COMPLETE   = 2'd2;
    localparam logic [1:0] EV_ERROR      = 2'd3;

    // Error codes
    localparam logic [3:0] ERR_NO_STAR        = 4'd0;
    localparam logic [3:0] ERR_BAD_COUNT_CHAR = 4'd1;
    localparam logic [3:0] ERR_COUNT_OVERFLOW = 4'd2;
    localparam logic [3:0] ERR_COUNT_TOO_BIG  = 4'd3;
    localparam logic [3:0] ERR_NULL_ARRAY     = 4'd4;
    localparam logic [3:0] ERR_EMPTY_ARRAY    = 4'd5;
    localparam logic [3:0] ERR_NO_DOLLAR      = 4'd6;
    localparam logic [3:0] ERR_BAD_LEN_CHAR   = 4'd7;
    localparam logic [3:0] ERR_LEN_OVERFLOW   = 4'd8;
    localparam logic [3:0] ERR_LEN_TOO_BIG    = 4'd9;
    localparam logic [3:0] ERR_NULL_BULK      = 4'd10;
    localparam logic [3:0] ERR_NO_DATA_CRLF   = 4'd11;
    localparam logic [3:0] ERR_CR_WITHOUT_LF  = 4'd12;

    // Configured limits
    typedef struct packed {
        logic [COUNT_W-1:0] max_array_count;
        logic [LEN_W-1:0]   max_bulk_length;
    } t_limits;

    // One result beat
    typedef struct packed {
        logic [1:0]         event_res;
        logic [7:0]         data_byte;
        logic               last_in_arg;
        logic [LEN_W-1:0]   arg_length;
        logic [INDEX_W-1:0] arg_index;
        logic [COUNT_W-1:0] arg_count;
        logic [3:0]         error_code;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/rrp_cfg_regs.sv]
// Limit registers written through the configuration channel.
// Depends on rrp_pkg for register indexes, reset values and t_limits.
`default_nettype none

module rrp_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rrp_pkg::t_limits                    o_limits
);
    import rrp_pkg::*;

    logic [COUNT_W-1:0] r_max_array_count;
    logic [LEN_W-1:0]   r_max_bulk_length;

    // Always ready: a write is registered when it is accepted
    assign o_cfg_ready = 1'b1;

    // Update the addressed limit, drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_array_count <= MAX_ARRAY_COUNT_RST;
            r_max_bulk_length <= MAX_BULK_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_ARRAY_COUNT: r_max_array_count <= i_cfg_data[COUNT_W-1:0];
                REG_MAX_BULK_LENGTH: r_max_bulk_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_limits.max_array_count = r_max_array_count;
    assign o_limits.max_bulk_length = r_max_bulk_length;

endmodule

`default_nettype wire

[hw/rtl/rrp_parse_core.sv]
// Parser state and per-byte next-state logic: one item per step strobe.
// Depends on rrp_pkg for phase, event and error codes and structs.
`default_nettype none

module rrp_parse_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_kind,
    input  wire logic [7:0]       i_data,
    input  wire rrp_pkg::t_limits i_limits,
    output logic                  o_res_valid,
    output rrp_pkg::t_result      o_res
);
    import rrp_pkg::*;

    logic [3:0]         r_phase,        n_phase;
    logic [COUNT_W-1:0] r_array_total,  n_array_total;
    logic [COUNT_W-1:0] r_args_seen,    n_args_seen;
    logic [LEN_W-1:0]   r_acc,          n_acc;
    logic [LEN_W-1:0]   r_bytes_left,   n_bytes_left;
    logic               r_minus_seen,   n_minus_seen;
    logic               r_err,          n_err;

    logic               is_count;
    logic [LEN_W-1:0]   limit;
    logic [LEN_W+3:0]   acc_x10;
    logic [LEN_W+3:0]   acc_digit;
    logic               dig_overflow;
    logic               dig_too_big;
    logic [LEN_W-1:0]   bytes_dec;
    logic [COUNT_W-1:0] args_inc;
    t_result            res;
    logic               res_valid;

    // Digit step: ten times the accumulator by shift and add, checked against the limit
    assign is_count     = (r_phase == PH_COUNT);
    assign limit        = is_count ? {{(LEN_W-COUNT_W){1'b0}}, i_limits.max_array_count}
                                   : i_limits.max_bulk_length;
    assign acc_x10      = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
    assign acc_digit    = acc_x10 + {{(LEN_W){1'b0}}, i_data[3:0]};
    assign dig_overflow = acc_x10 > {4'b0000, limit};
    assign dig_too_big  = acc_digit > {4'b0000, limit};
    assign bytes_dec    = r_bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
    assign args_inc     = r_args_seen + {{(COUNT_W-1){1'b0}}, 1'b1};

    // Next state and result for the item in the input stage
    always_comb begin
        n_phase       = r_phase;
        n_array_total = r_array_total;
        n_args_seen   = r_args_seen;
        n_acc         = r_acc;
        n_bytes_left  = r_bytes_left;
        n_minus_seen  = r_minus_seen;
        n_err         = r_err;
        res           = '0;
        res_valid     = 1'b0;

        if (i_kind) begin
            // Clear item: restart, no result
            n_phase       = PH_STAR;
            n_array_total = '0;
            n_args_seen   = '0;
            n_acc         = '0;
            n_bytes_left  = '0;
            n_minus_seen  = 1'b0;
            n_err         = 1'b0;
        end else if (!r_err) begin
            case (r_phase)
                PH_STAR: begin
                    if (i_data != CH_STAR) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_NO_STAR;
                    end else begin
                        n_acc        = '0;
                        n_minus_seen = 1'b0;
                        n_phase      = PH_COUNT;
                    end
                end
                PH_COUNT, PH_LEN: begin
                    if (i_data == CH_CR) begin
                        n_phase = is_count ? PH_COUNT_LF : PH_LEN_LF;
                    end else if (i_data == CH_MINUS) begin
                        n_minus_seen = 1'b1;
                    end else if (!(i_data inside {[CH_ZERO:CH_NINE]})) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = is_count ? ERR_BAD_COUNT_CHAR : ERR_BAD_LEN_CHAR;
                    end else if (dig_overflow) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = is_count ? ERR_COUNT_OVERFLOW : ERR_LEN_OVERFLOW;
                    end else if (dig_too_big) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = is_count ? ERR_COUNT_TOO_BIG : ERR_LEN_TOO_BIG;
                    end else begin
                        n_acc = acc_digit[LEN_W-1:0];
                    end
                end
                PH_COUNT_LF: begin
                    if (i_data != CH_LF) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_CR_WITHOUT_LF;
                    end else if (r_minus_seen) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_NULL_ARRAY;
                    end else if (r_acc == '0) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_EMPTY_ARRAY;
                    end else begin
                        n_array_total = r_acc[COUNT_W-1:0];
                        n_args_seen   = '0;
                        n_phase       = PH_DOLLAR;
                    end
                end
                PH_DOLLAR: begin
                    if (i_data != CH_DOLLAR) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_NO_DOLLAR;
                    end else begin
                        n_acc        = '0;
                        n_minus_seen = 1'b0;
                        n_phase      = PH_LEN;
                    end
                end
                PH_LEN_LF: begin
                    if (i_data != CH_LF) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_CR_WITHOUT_LF;
                    end else if (r_minus_seen) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_NULL_BULK;
                    end else begin
                        n_bytes_left   = r_acc;
                        n_phase        = (r_acc == '0) ? PH_DATA_CR : PH_DATA;
                        res_valid      = 1'b1;
                        res.event_res  = EV_ARG_HEADER;
                        res.arg_length = r_acc;
                        res.arg_index  = r_args_seen[INDEX_W-1:0];
                    end
                end
                PH_DATA: begin
                    n_bytes_left    = bytes_dec;
                    res_valid       = 1'b1;
                    res.event_res   = EV_ARG_DATA;
                    res.data_byte   = i_data;
                    res.last_in_arg = (bytes_dec == '0);
                    res.arg_index   = r_args_seen[INDEX_W-1:0];
                    if (bytes_dec == '0) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (i_data != CH_CR) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_NO_DATA_CRLF;
                    end else begin
                        n_phase = PH_DATA_LF;
                    end
                end
                PH_DATA_LF: begin
                    if (i_data != CH_LF) begin
                        res_valid = 1'b1;
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_NO_DATA_CRLF;
                    end else begin
                        n_args_seen = args_inc;
                        if (args_inc >= r_array_total) begin
                            n_phase       = PH_STAR;
                            res_valid     = 1'b1;
                            res.event_res = EV_COMPLETE;
                            res.arg_count = r_array_total;
                        end else begin
                            n_phase = PH_DOLLAR;
                        end
                    end
                end
                default: begin
                    n_phase = PH_STAR;
                end
            endcase

            // Latch any error until a clear item
            if (res_valid && (res.event_res == EV_ERROR)) begin
                n_err = 1'b1;
            end
        end
    end

    // Advance parser state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_STAR;
            r_array_total <= '0;
            r_args_seen   <= '0;
            r_acc         <= '0;
            r_bytes_left  <= '0;
            r_minus_seen  <= 1'b0;
            r_err         <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_array_total <= n_array_total;
            r_args_seen   <= n_args_seen;
            r_acc         <= n_acc;
            r_bytes_left  <= n_bytes_left;
            r_minus_seen  <= n_minus_seen;
            r_err         <= n_err;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

endmodule

`default_nettype wire

[hw/rtl/resp_request_parser.sv]
// Top level of the request parser: input stage, parser core, result stage.
// Depends on rrp_pkg, rrp_cfg_regs and rrp_parse_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per item:
//   i_kind = 0 with a stream byte in i_data, or i_kind = 1 to clear a
//   latched error and expect a new command. Output channel (o_out_valid /
//   i_out_ready) carries at most one result beat per item: argument header,
//   data byte, command complete or error.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the count
//   limit (index 0) and the length limit (index 1); always ready. Write
//   only while no item is in flight.
//   Path: an accepted item is held in the input register, then its result
//   is loaded into the result register and presented on the output.
//   Throughput: one item per cycle while the output is not stalled; the parser
//   state update is a single pass of next-state logic.
//   Stall: while a result waits on i_out_ready the input register still
//   takes one more beat, then o_in_ready drops until the result is taken.
//   Reset (synchronous, active low): both stages empty, parser expects '*',
//   limits return to their reset values. No clearing pass is needed.
`default_nettype none

module resp_request_parser (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Item input
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_kind,
    input  wire logic [7:0]                     i_data,
    // Result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_event_res,
    output logic [7:0]                          o_data_byte,
    output logic                                o_last_in_arg,
    output logic [rrp_pkg::LEN_W-1:0]           o_arg_length,
    output logic [rrp_pkg::INDEX_W-1:0]         o_arg_index,
    output logic [rrp_pkg::COUNT_W-1:0]         o_arg_count,
    output logic [3:0]                          o_error_code,
    // Configuration write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rrp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rrp_pkg::*;

    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_data;
    logic       r_out_valid;
    t_result    r_out;

    t_limits    limits;
    logic       advance;
    logic       res_valid;
    t_result    res;

    // Step the parser when the input stage holds a beat and the result stage can take it
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    rrp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    rrp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_kind      (r_in_kind),
        .i_data      (r_in_data),
        .i_limits    (limits),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input stage: load on accept, empty once consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_kind <= i_kind;
            r_in_data <= i_data;
        end
    end

    // Result stage: hold until taken, load when the step yields a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_data_byte   = r_out.data_byte;
    assign o_last_in_arg = r_out.last_in_arg;
    assign o_arg_length  = r_out.arg_length;
    assign o_arg_index   = r_out.arg_index;
    assign o_arg_count   = r_out.arg_count;
    assign o_error_code  = r_out.error_code;

endmodule

`default_nettype wire

[bench/tb_resp_request_parser.sv]
// Self-checking bench for resp_request_parser: directed framing table, then random commands.
// Predicts result beats with typed rows or a parser model; depends on rrp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_resp_request_parser;
    import rrp_pkg::*;

    // Index that names no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam t_result QUIET = '0;

    // One row of the directed table: the beat to send and, where typed, its result
    typedef struct packed {
        logic    kind;
        logic [7:0] data;
        logic    typed;
        t_result res;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind = 1'b0;
    logic [7:0]            i_data = 8'h00;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_event_res;
    logic [7:0]            o_data_byte;
    logic                  o_last_in_arg;
    logic [LEN_W-1:0]      o_arg_length;
    logic [INDEX_W-1:0]    o_arg_index;
    logic [COUNT_W-1:0]    o_arg_count;
    logic [3:0]            o_error_code;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    resp_request_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_data       (i_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_data_byte  (o_data_byte),
        .o_last_in_arg(o_last_in_arg),
        .o_arg_length (o_arg_length),
        .o_arg_index  (o_arg_index),
        .o_arg_count  (o_arg_count),
        .o_error_code (o_error_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Parser model state and its copy of the limits
    logic [3:0]         parse_phase = PH_STAR;
    logic [COUNT_W-1:0] array_total = '0;
    logic [COUNT_W-1:0] args_seen = '0;
    logic [LEN_W-1:0]   number_acc = '0;
    logic [LEN_W-1:0]   bytes_left = '0;
    logic               minus_seen = 1'b0;
    logic               parse_latched = 1'b0;
    logic [COUNT_W-1:0] lim_count = MAX_ARRAY_COUNT_RST;
    logic [LEN_W-1:0]   lim_len = MAX_BULK_LENGTH_RST;

    t_result pending_events[$];
    t_result want_res;
    t_row    directed_rows[27];
    int      mismatches = 0;
    int      items_done = 0;
    bit      in_steady = 1'b0;
    bit      out_steady = 1'b0;

    function automatic bit latch_error(output t_result res, input logic [3:0] code);
        parse_latched = 1'b1;
        res = '0;
        res.event_res = EV_ERROR;
        res.error_code = code;
        return 1'b1;
    endfunction

    // Advance the parser model by one beat; return 1 when the beat yields a result
    function automatic bit advance_parser(input logic kind, input logic [7:0] b,
                                          output t_result res);
        logic [63:0]      grown;
        logic [LEN_W-1:0] limit;
        bit               on_count;
        res = '0;
        if (kind) begin
            parse_phase = PH_STAR;
            array_total = '0;
            args_seen = '0;
            number_acc = '0;
            bytes_left = '0;
            minus_seen = 1'b0;
            parse_latched = 1'b0;
            return 1'b0;
        end
        if (parse_latched)
            return 1'b0;
        case (parse_phase)
            PH_STAR: begin
                if (b != CH_STAR)
                    return latch_error(res, ERR_NO_STAR);
                number_acc = '0;
                minus_seen = 1'b0;
                parse_phase = PH_COUNT;
            end
            PH_COUNT, PH_LEN: begin
                on_count = (parse_phase == PH_COUNT);
                limit = on_count ? LEN_W'(lim_count) : lim_len;
                if (b == CH_CR) begin
                    parse_phase = on_count ? PH_COUNT_LF : PH_LEN_LF;
                    return 1'b0;
                end
                if (b == CH_MINUS) begin
                    minus_seen = 1'b1;
                    return 1'b0;
                end
                if (b < CH_ZERO || b > CH_NINE)
                    return latch_error(res, on_count ? ERR_BAD_COUNT_CHAR : ERR_BAD_LEN_CHAR);
                if (number_acc > limit / 10)
                    return latch_error(res, on_count ? ERR_COUNT_OVERFLOW : ERR_LEN_OVERFLOW);
                grown = 64'(number_acc) * 10 + 64'(b - CH_ZERO);
                if (grown > 64'(limit))
                    return latch_error(res, on_count ? ERR_COUNT_TOO_BIG : ERR_LEN_TOO_BIG);
                number_acc = grown[LEN_W-1:0];
            end
            PH_COUNT_LF: begin
                if (b != CH_LF)
                    return latch_error(res, ERR_CR_WITHOUT_LF);
                if (minus_seen)
                    return latch_error(res, ERR_NULL_ARRAY);
                if (number_acc == 0)
                    return latch_error(res, ERR_EMPTY_ARRAY);
                array_total = number_acc[COUNT_W-1:0];
                args_seen = '0;
                parse_phase = PH_DOLLAR;
            end
            PH_DOLLAR: begin
                if (b != CH_DOLLAR)
                    return latch_error(res, ERR_NO_DOLLAR);
                number_acc = '0;
                minus_seen = 1'b0;
                parse_phase = PH_LEN;
            end
            PH_LEN_LF: begin
                if (b != CH_LF)
                    return latch_error(res, ERR_CR_WITHOUT_LF);
                if (minus_seen)
                    return latch_error(res, ERR_NULL_BULK);
                bytes_left = number_acc;
                parse_phase = (bytes_left == 0) ? PH_DATA_CR : PH_DATA;
                res.event_res = EV_ARG_HEADER;
                res.arg_length = bytes_left;
                res.arg_index = args_seen[INDEX_W-1:0];
                return 1'b1;
            end
            PH_DATA: begin
                bytes_left = bytes_left - 1'b1;
                res.event_res = EV_ARG_DATA;
                res.data_byte = b;
                res.last_in_arg = (bytes_left == 0);
                res.arg_index = args_seen[INDEX_W-1:0];
                if (bytes_left == 0)
                    parse_phase = PH_DATA_CR;
                return 1'b1;
            end
            PH_DATA_CR: begin
                if (b != CH_CR)
                    return latch_error(res, ERR_NO_DATA_CRLF);
                parse_phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
                if (b != CH_LF)
                    return latch_error(res, ERR_NO_DATA_CRLF);
                args_seen = args_seen + 1'b1;
                if (args_seen >= array_total) begin
                    parse_phase = PH_STAR;
                    res.event_res = EV_COMPLETE;
                    res.arg_count = array_total;
                    return 1'b1;
                end
                parse_phase = PH_DOLLAR;
            end
            default: parse_phase = PH_STAR;
        endcase
        return 1'b0;
    endfunction

    // Send one input beat after a random gap; queue what it should produce
    task automatic send_item(input logic kind, input logic [7:0] data,
                             input logic typed = 1'b0, input t_result typed_res = '0);
        int      gap;
        bit      has;
        t_result predicted;
        if ($urandom_range(0, 39) == 0)
            in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
        items_done++;
        has = advance_parser(kind, data, predicted);
        if (typed)
            pending_events.push_back(typed_res);
        else if (has)
            pending_events.push_back(predicted);
        @(negedge i_clk);
    endtask

    // Stream byte with occasional corruption: replace, drop or insert
    task automatic put_stream_byte(input logic [7:0] b);
        case ($urandom_range(0, 199))
            0: send_item(1'b0, 8'($urandom));
            1: ;
            2: begin
                send_item(1'b0, 8'($urandom));
                send_item(1'b0, b);
            end
            default: send_item(1'b0, b);
        endcase
    endtask

    // Decimal line with CR LF; sometimes empty, padded with a zero, or carrying a minus
    task automatic put_number(input longint value);
        string digits;
        int    i;
        int    minus_at;
        digits = "";
        if ($urandom_range(0, 29) != 0) begin
            digits = $sformatf("%0d", value);
            if ($urandom_range(0, 9) == 0)
                digits = {"0", digits};
        end
        minus_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, digits.len()) : -1;
        for (i = 0; i <= digits.len(); i++) begin
            if (i == minus_at)
                put_stream_byte(CH_MINUS);
            if (i < digits.len())
                put_stream_byte(digits[i]);
        end
        put_stream_byte(CH_CR);
        put_stream_byte(CH_LF);
    endtask

    // Mostly small values, some near the limit, a few far past it
    function automatic longint pick_value(input longint limit, input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(lo, hi);
        if (r < 88)
            return $urandom_range(lo, hi * 6);
        if (r < 95)
            return limit + $urandom_range(0, 1);
        return longint'($urandom) * 1000 + $urandom_range(0, 999);
    endfunction

    // One command with random content; clear first if the parser is stuck on an error
    task automatic send_command();
        longint n;
        longint len;
        int     i;
        int     k;
        if (parse_latched || $urandom_range(0, 19) == 0)
            send_item(1'b1, 8'($urandom));
        put_stream_byte(CH_STAR);
        n = pick_value(lim_count, 1, 3);
        put_number(n);
        for (i = 0; i < n && i < 20; i++) begin
            if (parse_latched)
                return;
            put_stream_byte(CH_DOLLAR);
            len = pick_value(lim_len, 0, 6);
            put_number(len);
            if (len > 64) begin
                // Too long to send in full: cut it short and clear
                repeat ($urandom_range(0, 3)) put_stream_byte(8'($urandom));
                send_item(1'b1, 8'($urandom));
                return;
            end
            for (k = 0; k < len; k++)
                put_stream_byte(($urandom_range(0, 7) == 0) ? CH_CR : 8'($urandom));
            put_stream_byte(CH_CR);
            put_stream_byte(CH_LF);
        end
    endtask

    // Hold input idle until every expected beat has come out and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Leave i_cfg_valid high; the caller drops it after its last write
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_MAX_ARRAY_COUNT)
            lim_count = value[COUNT_W-1:0];
        else if (idx == REG_MAX_BULK_LENGTH)
            lim_len = value[LEN_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: stall a random number of cycles before each beat
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_steady = !out_steady;
            stall = out_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready && i_rst_n));
            @(negedge i_clk);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result beat, event %0d", $time, o_event_res);
                mismatches++;
            end else begin
                want_res = pending_events.pop_front();
                check_field("event_res", want_res.event_res, o_event_res);
                check_field("data_byte", want_res.data_byte, o_data_byte);
                check_field("last_in_arg", want_res.last_in_arg, o_last_in_arg);
                check_field("arg_length", want_res.arg_length, o_arg_length);
                check_field("arg_index", want_res.arg_index, o_arg_index);
                check_field("arg_count", want_res.arg_count, o_arg_count);
                check_field("error_code", want_res.error_code, o_error_code);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("tb_resp_request_parser: errors");
        $finish;
    end

    initial begin
        int p;
        int target;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no star, sticky error, clear, empty length line, two-argument
        // command, minus in count, CR without LF
        directed_rows = '{
            '{1'b0, 8'h41, 1'b1,
              t_result'{EV_ERROR, 8'h00, 1'b0, 30'd0, 20'd0, 21'd0, ERR_NO_STAR}},
            '{1'b0, CH_STAR, 1'b0, QUIET},
            '{1'b1, 8'hFF, 1'b0, QUIET},
            '{1'b0, CH_STAR, 1'b0, QUIET},
            '{1'b0, 8'h32, 1'b0, QUIET},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, CH_LF, 1'b0, QUIET},
            '{1'b0, CH_DOLLAR, 1'b0, QUIET},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, CH_LF, 1'b1,
              t_result'{EV_ARG_HEADER, 8'h00, 1'b0, 30'd0, 20'd0, 21'd0, 4'd0}},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, CH_LF, 1'b0, QUIET},
            '{1'b0, CH_DOLLAR, 1'b0, QUIET},
            '{1'b0, 8'h31, 1'b0, QUIET},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, CH_LF, 1'b1,
              t_result'{EV_ARG_HEADER, 8'h00, 1'b0, 30'd1, 20'd1, 21'd0, 4'd0}},
            '{1'b0, 8'hFF, 1'b1,
              t_result'{EV_ARG_DATA, 8'hFF, 1'b1, 30'd0, 20'd1, 21'd0, 4'd0}},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, CH_LF, 1'b1,
              t_result'{EV_COMPLETE, 8'h00, 1'b0, 30'd0, 20'd0, 21'd2, 4'd0}},
            '{1'b0, CH_STAR, 1'b0, QUIET},
            '{1'b0, CH_MINUS, 1'b0, QUIET},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, CH_LF, 1'b1,
              t_result'{EV_ERROR, 8'h00, 1'b0, 30'd0, 20'd0, 21'd0, ERR_NULL_ARRAY}},
            '{1'b1, 8'h00, 1'b0, QUIET},
            '{1'b0, CH_STAR, 1'b0, QUIET},
            '{1'b0, CH_CR, 1'b0, QUIET},
            '{1'b0, 8'h00, 1'b1,
              t_result'{EV_ERROR, 8'h00, 1'b0, 30'd0, 20'd0, 21'd0, ERR_CR_WITHOUT_LF}}
        };
        foreach (directed_rows[r])
            send_item(directed_rows[r].kind, directed_rows[r].data,
                      directed_rows[r].typed, directed_rows[r].res);

        // Random commands under several limit settings
        for (p = 0; p < 5; p++) begin
            drain();
            case (p)
                1: begin
                    write_limit(REG_MAX_ARRAY_COUNT, 32'd1);
                    write_limit(REG_MAX_BULK_LENGTH, 32'd0);
                end
                2: begin
                    write_limit(REG_MAX_ARRAY_COUNT, 32'(MAX_ARRAY_COUNT_RST));
                    write_limit(REG_MAX_BULK_LENGTH, 32'(MAX_BULK_LENGTH_RST));
                end
                3: begin
                    write_limit(REG_MAX_ARRAY_COUNT, $urandom_range(2, 9));
                    write_limit(REG_MAX_BULK_LENGTH, $urandom_range(1, 20));
                end
                4: begin
                    write_limit(REG_SPARE, $urandom);
                    write_limit(REG_MAX_ARRAY_COUNT, $urandom);
                    write_limit(REG_MAX_BULK_LENGTH, $urandom);
                end
                default: ;
            endcase
            i_cfg_valid <= 1'b0;
            target = items_done + 120;
            while (items_done < target)
                send_command();
        end

        drain();
        if (mismatches == 0 && pending_events.size() == 0)
            $display("tb_resp_request_parser: clean");
        else
            $display("tb_resp_request_parser: errors");
        $finish;
    end

endmodule
